// File: hw/rtl/bidirectional_region_translator_assert.svh
// Assertion macros for the region translator.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef BIDIRECTIONAL_REGION_TRANSLATOR_ASSERT_SVH
`define BIDIRECTIONAL_REGION_TRANSLATOR_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define BRT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("region translator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("region translator assertion failed");

`else

`define BRT_ASSERT_SAME(label, ante, cons)
`define BRT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/brt_pkg.sv
package brt_pkg;

    // Width of every address field on the ports.
    localparam int DATA_W = 32;

    // Operation codes carried in the func field.
    typedef logic [1:0] func_t;
    localparam func_t FUNC_ADD = 2'd0;
    localparam func_t FUNC_P2V = 2'd1;
    localparam func_t FUNC_V2P = 2'd2;

    // One request item.
    typedef struct packed {
        func_t             func;
        logic [DATA_W-1:0] phys_addr;
        logic [DATA_W-1:0] virt_addr;
        logic [DATA_W-1:0] region_size;
    } req_t;

    // One response item.
    typedef struct packed {
        logic [DATA_W-1:0] addr_out;
        logic              ok;
    } rsp_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_XLATE,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

// File: hw/rtl/brt_range_unit.sv
// Shared range comparator: forms the inclusive end of a stored region and
// checks whether the query span [lo, hi] touches it.
module brt_range_unit #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic [ADDR_WIDTH-1:0] lo,
    input  logic [ADDR_WIDTH-1:0] hi,
    input  logic [ADDR_WIDTH-1:0] base,
    input  logic [ADDR_WIDTH-1:0] last,
    output logic                  hit
);

    logic [ADDR_WIDTH-1:0] region_end;

    // The end wraps modulo the address width.
    assign region_end = base + last;

    // A lookup passes lo == hi; an add passes its own start and end.
    assign hit = (hi >= base) && (lo <= region_end);

endmodule

// File: hw/rtl/bidirectional_region_translator.sv
// Region translator with up to MAX_REGIONS entries, each a physical base, a
// virtual base and an inclusive last offset, kept in a table memory with one
// read and one write port. One item is handled at a time and req_ready is high
// only while the sequencer is idle. A lookup compares one stored table entry
// per cycle, translates on a hit and then loads the output register; an add
// first forms the new region's ends, then has the single range comparator
// check the physical and the virtual side of each stored entry in turn, and
// then writes the entry and loads the output register. A response waits in an
// output register, and the next item is taken once it has been moved there. A
// miss answers all ones, an add answers zero.
`include "bidirectional_region_translator_assert.svh"

module bidirectional_region_translator #(
    parameter int MAX_REGIONS = 8,
    parameter int ADDR_WIDTH  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  brt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output brt_pkg::rsp_t rsp
);

    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam logic [ADDR_WIDTH-1:0] ADDR_ONES = '1;
    localparam logic [brt_pkg::DATA_W-1:0] MISS_ADDR = brt_pkg::DATA_W'(ADDR_ONES);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_REGIONS);

    brt_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             phase_reg, phase_next;
    logic             rsp_valid_reg, rsp_valid_next;

    brt_pkg::func_t        func_reg, func_next;
    logic [ADDR_WIDTH-1:0] p_reg, p_next;
    logic [ADDR_WIDTH-1:0] v_reg, v_next;
    logic [ADDR_WIDTH-1:0] last_reg, last_next;
    logic                  size_zero_reg, size_zero_next;
    logic [ADDR_WIDTH-1:0] p_end_reg, p_end_next;
    logic [ADDR_WIDTH-1:0] v_end_reg, v_end_next;
    logic [brt_pkg::DATA_W-1:0] res_addr_reg, res_addr_next;
    logic                  res_ok_reg, res_ok_next;
    brt_pkg::rsp_t         rsp_reg, rsp_next;

    // Region table.
    logic [ADDR_WIDTH-1:0] phys_mem [MAX_REGIONS];
    logic [ADDR_WIDTH-1:0] virt_mem [MAX_REGIONS];
    logic [ADDR_WIDTH-1:0] last_mem [MAX_REGIONS];
    logic [ADDR_WIDTH-1:0] rd_phys_reg, rd_virt_reg, rd_last_reg;
    logic [IDX_W-1:0]      rd_addr, wr_addr;
    logic                  wr_en;

    logic [ADDR_WIDTH-1:0] unit_lo, unit_hi, unit_base;
    logic                  unit_hit;
    logic [ADDR_WIDTH-1:0] xl_query, xl_from, xl_to, xl_addr;
    logic [CNT_W-1:0]      idx_inc;
    logic                  last_entry;

    assign req_ready = (state_reg == brt_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign idx_inc    = idx_reg + CNT_W'(1);
    assign last_entry = (idx_inc == count_reg);
    assign rd_addr    = idx_next[IDX_W-1:0];
    assign wr_addr    = count_reg[IDX_W-1:0];

    // Operand selection for the shared comparator.
    always_comb
    begin
        if (func_reg == brt_pkg::FUNC_ADD)
        begin
            unit_base = phase_reg ? rd_virt_reg : rd_phys_reg;
            unit_lo   = phase_reg ? v_reg : p_reg;
            unit_hi   = phase_reg ? v_end_reg : p_end_reg;
        end
        else if (func_reg == brt_pkg::FUNC_P2V)
        begin
            unit_base = rd_phys_reg;
            unit_lo   = p_reg;
            unit_hi   = p_reg;
        end
        else
        begin
            unit_base = rd_virt_reg;
            unit_lo   = v_reg;
            unit_hi   = v_reg;
        end
    end

    brt_range_unit #(
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_range (
        .lo  (unit_lo),
        .hi  (unit_hi),
        .base(unit_base),
        .last(rd_last_reg),
        .hit (unit_hit)
    );

    // Base-relative translation through the entry that hit.
    always_comb
    begin
        if (func_reg == brt_pkg::FUNC_P2V)
        begin
            xl_query = p_reg;
            xl_from  = rd_phys_reg;
            xl_to    = rd_virt_reg;
        end
        else
        begin
            xl_query = v_reg;
            xl_from  = rd_virt_reg;
            xl_to    = rd_phys_reg;
        end
        xl_addr = xl_query - xl_from + xl_to;
    end

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        func_next      = func_reg;
        p_next         = p_reg;
        v_next         = v_reg;
        last_next      = last_reg;
        size_zero_next = size_zero_reg;
        p_end_next     = p_end_reg;
        v_end_next     = v_end_reg;
        res_addr_next  = res_addr_reg;
        res_ok_next    = res_ok_reg;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;

        case (state_reg)
            brt_pkg::ST_IDLE:
            begin
                idx_next   = '0;
                phase_next = 1'b0;
                if (req_valid)
                begin
                    func_next      = req.func;
                    p_next         = ADDR_WIDTH'(req.phys_addr);
                    v_next         = ADDR_WIDTH'(req.virt_addr);
                    last_next      = ADDR_WIDTH'(req.region_size) - ADDR_WIDTH'(1);
                    size_zero_next = (ADDR_WIDTH'(req.region_size) == '0);
                    res_addr_next  = '0;
                    res_ok_next    = 1'b0;
                    case (req.func)
                        brt_pkg::FUNC_ADD:
                        begin
                            state_next = brt_pkg::ST_PREP;
                        end
                        brt_pkg::FUNC_P2V, brt_pkg::FUNC_V2P:
                        begin
                            res_addr_next = MISS_ADDR;
                            state_next = (count_reg == '0) ? brt_pkg::ST_DONE
                                                           : brt_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            state_next = brt_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // Form the inclusive ends of the new region and check the easy refusals.
            brt_pkg::ST_PREP:
            begin
                p_end_next = p_reg + last_reg;
                v_end_next = v_reg + last_reg;
                if (size_zero_reg || (count_reg == FULL_COUNT))
                begin
                    state_next = brt_pkg::ST_DONE;
                end
                else if (count_reg == '0)
                begin
                    state_next = brt_pkg::ST_WRITE;
                end
                else
                begin
                    state_next = brt_pkg::ST_SCAN;
                end
            end

            // One comparison per cycle against the entry read from the table.
            brt_pkg::ST_SCAN:
            begin
                if (func_reg == brt_pkg::FUNC_ADD)
                begin
                    if (unit_hit)
                    begin
                        state_next = brt_pkg::ST_DONE;
                    end
                    else if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        if (last_entry)
                        begin
                            state_next = brt_pkg::ST_WRITE;
                        end
                        else
                        begin
                            idx_next = idx_inc;
                        end
                    end
                end
                else if (unit_hit)
                begin
                    state_next = brt_pkg::ST_XLATE;
                end
                else if (last_entry)
                begin
                    state_next = brt_pkg::ST_DONE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            brt_pkg::ST_XLATE:
            begin
                res_addr_next = brt_pkg::DATA_W'(xl_addr);
                res_ok_next   = 1'b1;
                state_next    = brt_pkg::ST_DONE;
            end

            brt_pkg::ST_WRITE:
            begin
                wr_en       = 1'b1;
                count_next  = count_reg + CNT_W'(1);
                res_ok_next = 1'b1;
                state_next  = brt_pkg::ST_DONE;
            end

            // Hand the item to the output register once it is free.
            brt_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.addr_out = res_addr_reg;
                    rsp_next.ok       = res_ok_reg;
                    state_next        = brt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = brt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= brt_pkg::ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            phase_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        p_reg         <= p_next;
        v_reg         <= v_next;
        last_reg      <= last_next;
        size_zero_reg <= size_zero_next;
        p_end_reg     <= p_end_next;
        v_end_reg     <= v_end_next;
        res_addr_reg  <= res_addr_next;
        res_ok_reg    <= res_ok_next;
        rsp_reg       <= rsp_next;
    end

    // Table memory: new entries go in at the fill count, reads are registered.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            phys_mem[wr_addr] <= p_reg;
            virt_mem[wr_addr] <= v_reg;
            last_mem[wr_addr] <= last_reg;
        end
        rd_phys_reg <= phys_mem[rd_addr];
        rd_virt_reg <= virt_mem[rd_addr];
        rd_last_reg <= last_mem[rd_addr];
    end

    // The fill count never passes the table depth.
    `BRT_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= FULL_COUNT)

    // The scan only visits entries that have been written.
    `BRT_ASSERT_SAME(a_scan_in_table, state_reg == brt_pkg::ST_SCAN, idx_reg < count_reg)

    // The fill count moves only when an entry is written.
    `BRT_ASSERT_NEXT(a_count_on_write, state_reg != brt_pkg::ST_WRITE,
                     count_reg == $past(count_reg))

    // A response appears only as the sequencer finishes an item.
    `BRT_ASSERT_SAME(a_rsp_from_done, $rose(rsp_valid_reg),
                     $past(state_reg) == brt_pkg::ST_DONE)

endmodule
